// ----- sv/mfr_pkg.sv -----
package mfr_pkg;

  localparam int unsigned SYNC_W = 24;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_DATA_W = SYNC_W;

  localparam logic [3:0] NO_PAIR = 4'hF;

  typedef enum logic [1:0] {
    REG_SYNC_PATTERN   = 2'd0,
    REG_TRAILER_CODE   = 2'd1,
    REG_LOST_SYNC_CODE = 2'd2,
    REG_RAW_CAPACITY   = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_COLLISION  = 3'd1,
    ST_LOST_SYNC  = 3'd2,
    ST_MANCHESTER = 3'd3,
    ST_OVERRUN    = 3'd4
  } end_status_t;

  localparam logic [SYNC_W-1:0] SYNC_PATTERN_RST   = 24'h335553;
  localparam logic [BYTE_W-1:0] TRAILER_CODE_RST   = 8'h35;
  localparam logic [BYTE_W-1:0] LOST_SYNC_CODE_RST = 8'hFF;
  localparam logic [BYTE_W-1:0] RAW_CAPACITY_RST   = 8'hFF;
  localparam logic [BYTE_W-1:0] COLLISION_CODE     = 8'h00;

  typedef struct packed {
    logic [SYNC_W-1:0] sync_pattern;
    logic [BYTE_W-1:0] trailer_code;
    logic [BYTE_W-1:0] lost_sync_code;
    logic [BYTE_W-1:0] raw_capacity;
  } cfg_t;

  typedef struct packed {
    logic              in_message;
    logic [SYNC_W-1:0] sync_window;
    logic [BYTE_W-1:0] stored_count;
    logic              half_done;
    logic [BYTE_W-1:0] partial_byte;
  } frame_state_t;

  typedef struct packed {
    logic              valid;
    logic              has_byte;
    logic [BYTE_W-1:0] message_byte;
    logic              frame_end;
    end_status_t       end_status;
    logic [BYTE_W-1:0] raw_count;
  } result_t;

  // Manchester nibble to two data bits; NO_PAIR for codes that are not a valid pair.
  function automatic logic [3:0] pair_of_nibble(input logic [3:0] nib);
    logic [3:0] pair;
    unique case (nib)
      4'h5:    pair = 4'h3;
      4'h6:    pair = 4'h2;
      4'h9:    pair = 4'h1;
      4'hA:    pair = 4'h0;
      default: pair = NO_PAIR;
    endcase
    return pair;
  endfunction

endpackage

// ----- sv/mfr_step.sv -----
module mfr_step (
  input  mfr_pkg::cfg_t         cfg,
  input  mfr_pkg::frame_state_t st,
  input  logic [7:0]            rx_byte,
  output mfr_pkg::frame_state_t st_nxt,
  output mfr_pkg::result_t      res
);
  import mfr_pkg::*;

  logic [3:0]        hi;
  logic [3:0]        lo;
  logic [SYNC_W-1:0] window;
  logic              ended;
  logic              has_byte;
  logic [BYTE_W-1:0] msg;
  end_status_t       status;

  assign hi     = pair_of_nibble(rx_byte[7:4]);
  assign lo     = pair_of_nibble(rx_byte[3:0]);
  assign window = {st.sync_window[SYNC_W-BYTE_W-1:0], rx_byte};

  always_comb begin
    st_nxt   = st;
    ended    = 1'b0;
    has_byte = 1'b0;
    msg      = '0;
    status   = ST_OK;

    priority if (!st.in_message) begin
      st_nxt.sync_window = window;
      if (window == cfg.sync_pattern) begin
        st_nxt.in_message = 1'b1;
      end
    end else if (rx_byte == COLLISION_CODE) begin
      ended  = 1'b1;
      status = ST_COLLISION;
    end else if (rx_byte == cfg.lost_sync_code) begin
      ended  = 1'b1;
      status = ST_LOST_SYNC;
    end else if (rx_byte == cfg.trailer_code) begin
      ended  = 1'b1;
      status = ST_OK;
    end else begin
      st_nxt.stored_count = st.stored_count + 8'd1;
      if (hi == NO_PAIR || lo == NO_PAIR) begin
        ended  = 1'b1;
        status = ST_MANCHESTER;
      end else begin
        st_nxt.partial_byte = {st.partial_byte[3:0], hi[1:0], lo[1:0]};
        st_nxt.half_done    = ~st.half_done;
        // second nibble completes the byte
        if (st.half_done) begin
          has_byte = 1'b1;
          msg      = {st.partial_byte[3:0], hi[1:0], lo[1:0]};
        end
      end
    end

    if (st_nxt.in_message && !ended && st_nxt.stored_count >= cfg.raw_capacity) begin
      ended  = 1'b1;
      status = ST_OVERRUN;
    end

    res.valid        = has_byte || ended;
    res.has_byte     = has_byte;
    res.message_byte = msg;
    res.frame_end    = ended;
    res.end_status   = ended ? status : ST_OK;
    res.raw_count    = ended ? st_nxt.stored_count : '0;

    // back to hunting with a clean frame
    if (ended) begin
      st_nxt = '0;
    end
  end

endmodule

// ----- sv/manchester_frame_receiver.sv -----
// Channel  Ports                              Moves
// in       in_valid / in_ready / in_rx_byte   one raw radio byte per request
// out      out_valid / out_ready / out_*      one decoded byte and/or frame end
// cfg      cfg_we / cfg_index / cfg_wdata     register write, no handshake
//
// One byte per cycle while in_ready is high: the whole per-byte step is a single
// combinational pass from the frame state registers to the result register.
// A byte that gives no result updates state only; a result is shown in the next cycle.
// Synchronous active-low reset clears frame state and out_valid, resets cfg registers.
// in_ready drops only while a result waits in the output register and out_ready is low.
module manchester_frame_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_has_byte,
  output logic [7:0]                     out_message_byte,
  output logic                           out_frame_end,
  output logic [2:0]                     out_end_status,
  output logic [7:0]                     out_raw_count,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [mfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mfr_pkg::*;

  cfg_t         cfg_r;
  frame_state_t st_r;
  frame_state_t st_nxt;
  result_t      res;
  result_t      out_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         accept;

  mfr_step u_step (
    .cfg     (cfg_r),
    .st      (st_r),
    .rx_byte (in_rx_byte),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (accept) begin
      out_valid_nxt = res.valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_pattern   <= SYNC_PATTERN_RST;
      cfg_r.trailer_code   <= TRAILER_CODE_RST;
      cfg_r.lost_sync_code <= LOST_SYNC_CODE_RST;
      cfg_r.raw_capacity   <= RAW_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SYNC_PATTERN:   cfg_r.sync_pattern   <= cfg_wdata;
        REG_TRAILER_CODE:   cfg_r.trailer_code   <= cfg_wdata[BYTE_W-1:0];
        REG_LOST_SYNC_CODE: cfg_r.lost_sync_code <= cfg_wdata[BYTE_W-1:0];
        REG_RAW_CAPACITY:   cfg_r.raw_capacity   <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload loads only with a result that will be shown
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_byte     = out_r.has_byte;
  assign out_message_byte = out_r.message_byte;
  assign out_frame_end    = out_r.frame_end;
  assign out_end_status   = out_r.end_status;
  assign out_raw_count    = out_r.raw_count;

endmodule

// ----- sv/mfr_checker.sv -----
module mfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_has_byte,
  input logic [7:0] out_message_byte,
  input logic       out_frame_end,
  input logic [2:0] out_end_status,
  input logic [7:0] out_raw_count
);
  import mfr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_has_byte)
      && $stable(out_message_byte) && $stable(out_frame_end)
      && $stable(out_end_status) && $stable(out_raw_count))
    else $error("result changed while stalled");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_has_byte || out_frame_end)
    else $error("empty result shown");

  a_no_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_end_status == ST_OK && out_raw_count == 8'd0)
    else $error("end fields set without frame end");

  a_no_byte_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_message_byte == 8'd0)
    else $error("message byte set without has_byte");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_end_status == ST_OK
      || out_end_status == ST_COLLISION || out_end_status == ST_LOST_SYNC
      || out_end_status == ST_MANCHESTER || out_end_status == ST_OVERRUN)
    else $error("end status code out of range");

endmodule

bind manchester_frame_receiver mfr_checker u_mfr_checker (.*);

// ----- sim/manchester_frame_receiver_tb.sv -----
`timescale 1ns / 100ps

module manchester_frame_receiver_tb;
  import mfr_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 210;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  message_byte;
    logic        frame_end;
    end_status_t status;
    logic [7:0]  raw_count;
  } rx_result_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_KNOWN, ROW_CAPACITY} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] value;
    rx_result_t result;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_has_byte;
  logic [7:0]            out_message_byte;
  logic                  out_frame_end;
  logic [2:0]            out_end_status;
  logic [7:0]            out_raw_count;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_SYNC_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cfg_t         rx_cfg;
  frame_state_t rx_state;
  rx_result_t   pending_decodes [$];
  int           err_count = 0;
  int           sent_items = 0;
  int           ready_hold = 0;
  int           idle_cycles = 0;
  bit           in_steady = 1'b0;
  bit           out_steady = 1'b0;

  // Reset configuration unless a capacity row says otherwise.
  directed_row_t directed_rows [0:30] = '{
    '{ROW_BYTE, 8'h00, '0},
    '{ROW_BYTE, 8'hFF, '0},
    '{ROW_BYTE, 8'h33, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_BYTE, 8'h53, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_BYTE, 8'hA6, '0},
    '{ROW_KNOWN, 8'hFF, '{1'b0, 8'h00, 1'b1, ST_LOST_SYNC, 8'd2}},
    '{ROW_BYTE, 8'h33, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_BYTE, 8'h53, '0},
    '{ROW_KNOWN, 8'h00, '{1'b0, 8'h00, 1'b1, ST_COLLISION, 8'd0}},
    '{ROW_BYTE, 8'h33, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_BYTE, 8'h53, '0},
    '{ROW_BYTE, 8'h59, '0},
    // trailer drops the pending half byte
    '{ROW_KNOWN, 8'h35, '{1'b0, 8'h00, 1'b1, ST_OK, 8'd1}},
    '{ROW_BYTE, 8'h33, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_BYTE, 8'h53, '0},
    '{ROW_KNOWN, 8'h5C, '{1'b0, 8'h00, 1'b1, ST_MANCHESTER, 8'd1}},
    // zero capacity overruns on the byte that completes the sync word
    '{ROW_CAPACITY, 8'd0, '0},
    '{ROW_BYTE, 8'h33, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_KNOWN, 8'h53, '{1'b0, 8'h00, 1'b1, ST_OVERRUN, 8'd0}},
    // message byte and overrun in one request
    '{ROW_CAPACITY, 8'd2, '0},
    '{ROW_BYTE, 8'h33, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_BYTE, 8'h53, '0},
    '{ROW_BYTE, 8'h55, '0},
    '{ROW_BYTE, 8'h5A, '0}
  };

  always #HALF_PERIOD clk = ~clk;

  manchester_frame_receiver DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_has_byte     (out_has_byte),
    .out_message_byte (out_message_byte),
    .out_frame_end    (out_frame_end),
    .out_end_status   (out_end_status),
    .out_raw_count    (out_raw_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  function automatic bit decode_rx_byte(input logic [7:0] rx, output rx_result_t res);
    logic ended;
    res   = '0;
    ended = 1'b0;
    if (!rx_state.in_message) begin
      rx_state.sync_window = {rx_state.sync_window[15:0], rx};
      if (rx_state.sync_window == rx_cfg.sync_pattern) rx_state.in_message = 1'b1;
    end else if (rx == COLLISION_CODE) begin
      ended      = 1'b1;
      res.status = ST_COLLISION;
    end else if (rx == rx_cfg.lost_sync_code) begin
      ended      = 1'b1;
      res.status = ST_LOST_SYNC;
    end else if (rx == rx_cfg.trailer_code) begin
      ended      = 1'b1;
      res.status = ST_OK;
    end else begin
      rx_state.stored_count = rx_state.stored_count + 8'd1;
      // each nibble must be a complementary bit pair twice over
      if (!((rx[7] ^ rx[6]) & (rx[5] ^ rx[4]) & (rx[3] ^ rx[2]) & (rx[1] ^ rx[0]))) begin
        ended      = 1'b1;
        res.status = ST_MANCHESTER;
      end else begin
        rx_state.partial_byte = {rx_state.partial_byte[3:0], rx[6], rx[4], rx[2], rx[0]};
        rx_state.half_done    = ~rx_state.half_done;
        if (!rx_state.half_done) begin
          res.has_byte     = 1'b1;
          res.message_byte = rx_state.partial_byte;
        end
      end
    end
    if (rx_state.in_message && !ended && rx_state.stored_count >= rx_cfg.raw_capacity) begin
      ended      = 1'b1;
      res.status = ST_OVERRUN;
    end
    if (ended) begin
      res.frame_end = 1'b1;
      res.raw_count = rx_state.stored_count;
      rx_state      = '0;
    end
    return res.has_byte || res.frame_end;
  endfunction

  function automatic logic [7:0] manchester_byte();
    logic [3:0] data;
    data = 4'($urandom_range(0, 15));
    return {~data[3], data[3], ~data[2], data[2], ~data[1], data[1], ~data[0], data[0]};
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      err_count++;
    end
  endfunction

  task automatic send_rx(input logic [7:0] rx, input bit known, input rx_result_t known_result);
    int         gap;
    bit         produced;
    rx_result_t res;
    gap = in_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    produced = decode_rx_byte(rx, res);
    if (known) begin
      pending_decodes.push_back(known_result);
    end else if (produced) begin
      pending_decodes.push_back(res);
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_SYNC_PATTERN:   rx_cfg.sync_pattern   = data;
      REG_TRAILER_CODE:   rx_cfg.trailer_code   = data[7:0];
      REG_LOST_SYNC_CODE: rx_cfg.lost_sync_code = data[7:0];
      REG_RAW_CAPACITY:   rx_cfg.raw_capacity   = data[7:0];
    endcase
  endtask

  task automatic run_phase(input int ph);
    logic [23:0] sync_word;
    logic [15:0] upper;
    logic [7:0]  trailer;
    logic [7:0]  lost_code;
    logic [7:0]  capacity;
    int          target;
    int          pause_at;
    int          len;
    int          pick;
    bit          paused;
    case (ph)
      0: begin
        sync_word = 24'h000000;
        trailer   = 8'hFF;
        lost_code = 8'h00;
        capacity  = 8'd1;
      end
      1: begin
        sync_word = 24'hFFFFFF;
        trailer   = 8'h00;
        lost_code = 8'hFF;
        capacity  = 8'd255;
      end
      2: begin
        sync_word = SYNC_PATTERN_RST;
        trailer   = TRAILER_CODE_RST;
        lost_code = LOST_SYNC_CODE_RST;
        capacity  = RAW_CAPACITY_RST;
      end
      default: begin
        sync_word = 24'($urandom_range(0, 24'hFFFFFF));
        trailer   = 8'($urandom_range(0, 255));
        lost_code = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0:       capacity = 8'd1;
          1:       capacity = 8'd2;
          2:       capacity = 8'd255;
          default: capacity = 8'($urandom_range(3, 40));
        endcase
      end
    endcase
    // junk in the unused upper bits of the narrow registers
    upper = (ph < 3) ? 16'h0000 : 16'($urandom);
    wait_idle();
    write_reg(REG_SYNC_PATTERN, sync_word);
    write_reg(REG_TRAILER_CODE, {upper, trailer});
    write_reg(REG_LOST_SYNC_CODE, {upper, lost_code});
    write_reg(REG_RAW_CAPACITY, {upper, capacity});
    in_steady  = (ph % 4 == 1) || (ph % 4 == 3);
    out_steady = (ph % 4 == 2) || (ph % 4 == 3);
    target   = sent_items + PHASE_ITEMS;
    pause_at = sent_items + PHASE_ITEMS / 2;
    paused   = 1'b0;
    while (sent_items < target) begin
      if (!paused && sent_items >= pause_at) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_rx(sync_word[23:16], 1'b0, '0);
        send_rx(sync_word[15:8], 1'b0, '0);
        send_rx(sync_word[7:0], 1'b0, '0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        repeat (len) send_rx(manchester_byte(), 1'b0, '0);
        case ($urandom_range(0, 4))
          0:       send_rx(trailer, 1'b0, '0);
          1:       send_rx(lost_code, 1'b0, '0);
          2:       send_rx(COLLISION_CODE, 1'b0, '0);
          3:       send_rx(8'($urandom_range(0, 255)), 1'b0, '0);
          default: ;
        endcase
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 8)) send_rx(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        // broken sync word
        send_rx(sync_word[23:16], 1'b0, '0);
        if ($urandom_range(0, 1)) send_rx(sync_word[15:8], 1'b0, '0);
        send_rx(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        $error("unexpected result: has_byte %0d frame_end %0d", out_has_byte, out_frame_end);
        err_count++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("has_byte", 8'(want.has_byte), 8'(out_has_byte));
        check_field("message_byte", want.message_byte, out_message_byte);
        check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
        check_field("end_status", 8'(want.status), 8'(out_end_status));
        check_field("raw_count", want.raw_count, out_raw_count);
      end
      ready_hold = out_steady ? 0 : $urandom_range(0, 6);
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rx_cfg.sync_pattern   = SYNC_PATTERN_RST;
    rx_cfg.trailer_code   = TRAILER_CODE_RST;
    rx_cfg.lost_sync_code = LOST_SYNC_CODE_RST;
    rx_cfg.raw_capacity   = RAW_CAPACITY_RST;
    rx_state              = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CAPACITY: begin
          wait_idle();
          write_reg(REG_RAW_CAPACITY, {16'h0000, directed_rows[i].value});
        end
        ROW_KNOWN: send_rx(directed_rows[i].value, 1'b1, directed_rows[i].result);
        default:   send_rx(directed_rows[i].value, 1'b0, '0);
      endcase
    end
    for (int ph = 0; ph < PHASES; ph++) run_phase(ph);
    wait_idle();
    if (err_count == 0 && pending_decodes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- manchester_frame_receiver.f -----
sv/mfr_pkg.sv
sv/mfr_step.sv
sv/manchester_frame_receiver.sv
sv/mfr_checker.sv
sim/manchester_frame_receiver_tb.sv
